// ----- src/lshf_pkg.sv -----
// Shared types and constants for the stack and history queue block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package lshf_pkg;

  localparam int LSHF_STACK_DEPTH   = 64;
  localparam int LSHF_HISTORY_DEPTH = 64;
  localparam int LSHF_TAG_WIDTH     = 32;

  localparam int TAG_PORT_W = 32;
  localparam int COUNT_W    = 7;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_CLOSE   = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_RESTORE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_STACK_EMPTY   = 2'd1,
    ST_HISTORY_EMPTY = 2'd2,
    ST_FULL          = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    CELL_HOLD = 4'b0001,
    CELL_PREV = 4'b0010,
    CELL_NEXT = 4'b0100,
    CELL_NEW  = 4'b1000
  } cell_mode_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic append;
  } chain_ctl_t;

endpackage

// ----- src/lshf_if.sv -----
// Valid/ready channel interfaces for command beats and result beats.
// Depends on lshf_pkg.
`timescale 1ns / 1ps

interface lshf_cmd_if;
  import lshf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            command;
  logic [TAG_PORT_W-1:0] tag_in;

  modport source (output valid, command, tag_in, input ready);
  modport sink   (input valid, command, tag_in, output ready);
endinterface

interface lshf_res_if;
  import lshf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [TAG_PORT_W-1:0] tag_out;
  logic [1:0]            status;
  logic [COUNT_W-1:0]    stack_count;
  logic [COUNT_W-1:0]    history_count;

  modport source (output valid, tag_out, status, stack_count, history_count, input ready);
  modport sink   (input valid, tag_out, status, stack_count, history_count, output ready);
endinterface

// ----- src/lshf_cell.sv -----
// One tag chain cell: holds a tag or loads a neighbor's tag or the new tag.
// Depends on lshf_pkg.
`timescale 1ns / 1ps

module lshf_cell #(
  parameter int TAG_WIDTH = lshf_pkg::LSHF_TAG_WIDTH
) (
  input  logic                   clk,
  input  lshf_pkg::cell_mode_t   mode,
  input  logic [TAG_WIDTH-1:0]   prev_tag,
  input  logic [TAG_WIDTH-1:0]   next_tag,
  input  logic [TAG_WIDTH-1:0]   new_tag,
  output logic [TAG_WIDTH-1:0]   q
);
  import lshf_pkg::*;

  always_ff @(posedge clk) begin
    case (mode)
      CELL_PREV: q <= prev_tag;
      CELL_NEXT: q <= next_tag;
      CELL_NEW:  q <= new_tag;
      default:   q <= q;
    endcase
  end

endmodule

// ----- src/lshf_chain.sv -----
// Row of tag cells with the front at cell 0: push/pop shift the row,
// append loads the cell at a given index. Depends on lshf_pkg, lshf_cell.
`timescale 1ns / 1ps

module lshf_chain #(
  parameter int DEPTH     = lshf_pkg::LSHF_STACK_DEPTH,
  parameter int TAG_WIDTH = lshf_pkg::LSHF_TAG_WIDTH,
  parameter int IDX_W     = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  lshf_pkg::chain_ctl_t   ctl,
  input  logic [IDX_W-1:0]       idx,
  input  logic [TAG_WIDTH-1:0]   new_tag,
  output logic [TAG_WIDTH-1:0]   front
);
  import lshf_pkg::*;

  logic [TAG_WIDTH-1:0] tags [DEPTH];

  assign front = tags[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [TAG_WIDTH-1:0] prev_tag;
    logic [TAG_WIDTH-1:0] next_tag;
    cell_mode_t           mode;

    if (i == 0) begin : g_first
      assign prev_tag = new_tag;
    end else begin : g_mid
      assign prev_tag = tags[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_tag = tags[i];
    end else begin : g_rest
      assign next_tag = tags[i+1];
    end

    always_comb begin
      if (ctl.push) begin
        mode = CELL_PREV;
      end else if (ctl.pop) begin
        mode = CELL_NEXT;
      end else if (ctl.append && idx == IDX_W'(i)) begin
        mode = CELL_NEW;
      end else begin
        mode = CELL_HOLD;
      end
    end

    lshf_cell #(.TAG_WIDTH(TAG_WIDTH)) u_cell (
      .clk      (clk),
      .mode     (mode),
      .prev_tag (prev_tag),
      .next_tag (next_tag),
      .new_tag  (new_tag),
      .q        (tags[i])
    );
  end

endmodule

// ----- src/lifo_stack_with_history_fifo_unit.sv -----
// Top level: command decode, occupancy counters, stack and history chains,
// result register. Depends on lshf_pkg, lshf_if, lshf_chain.
//
// Usage:
//   cmd channel (sink): one beat per command, command and tag_in.
//     push, close (stack top into history), peek, restore (oldest history
//     entry back onto the stack).
//   res channel (source): exactly one beat per command with the moved or
//     read tag, a status code and both occupancy counts after the command.
//   Timing: the result is registered and appears the cycle after acceptance.
//   Throughput: one command per cycle while res.ready is high. Each command
//     reads or inserts only at cell 0 of the stack chain and at the ends of
//     the history chain, and the cells shift or load in that same cycle.
//   Stall: the result register holds while res.ready is low; cmd.ready is
//     low only in reset or while that register is full and not drained,
//     so a new command is taken in the same cycle the waiting result leaves.
//   Reset: synchronous; both counts go to zero, the result register empties
//     and cmd.ready is low. Tag cells are not cleared; only occupied
//     cells are ever read.
`timescale 1ns / 1ps

module lifo_stack_with_history_fifo_unit #(
  parameter int STACK_DEPTH   = lshf_pkg::LSHF_STACK_DEPTH,
  parameter int HISTORY_DEPTH = lshf_pkg::LSHF_HISTORY_DEPTH,
  parameter int TAG_WIDTH     = lshf_pkg::LSHF_TAG_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  lshf_cmd_if.sink    cmd,
  lshf_res_if.source  res
);
  import lshf_pkg::*;

  localparam int SLW = $clog2(STACK_DEPTH + 1);
  localparam int HLW = $clog2(HISTORY_DEPTH + 1);

  logic [SLW-1:0] stack_level;
  logic [SLW-1:0] stack_level_next;
  logic [HLW-1:0] history_level;
  logic [HLW-1:0] history_level_next;

  logic accept;
  logic [TAG_WIDTH-1:0] tag_in_w;
  logic [TAG_WIDTH+TAG_PORT_W-1:0] tag_in_ext;
  logic [TAG_WIDTH-1:0] stack_front;
  logic [TAG_WIDTH-1:0] hist_front;
  logic [TAG_WIDTH-1:0] stack_new;
  logic [TAG_WIDTH-1:0] result;
  logic [TAG_WIDTH+TAG_PORT_W-1:0] result_ext;
  logic [SLW+COUNT_W-1:0] sc_ext;
  logic [HLW+COUNT_W-1:0] hc_ext;
  status_t status;
  chain_ctl_t stack_ctl;
  chain_ctl_t hist_ctl;

  logic stack_empty, stack_full, hist_empty, hist_full;

  assign cmd.ready = !rst && (!res.valid || res.ready);
  assign accept    = cmd.valid && cmd.ready;

  assign tag_in_ext = {{TAG_WIDTH{1'b0}}, cmd.tag_in};
  assign tag_in_w   = tag_in_ext[TAG_WIDTH-1:0];

  assign stack_empty = stack_level == '0;
  assign stack_full  = stack_level == SLW'(STACK_DEPTH);
  assign hist_empty  = history_level == '0;
  assign hist_full   = history_level == HLW'(HISTORY_DEPTH);

  always_comb begin
    stack_ctl          = '0;
    hist_ctl           = '0;
    stack_new          = tag_in_w;
    result             = '0;
    status             = ST_OK;
    stack_level_next   = stack_level;
    history_level_next = history_level;
    case (cmd_t'(cmd.command))
      CMD_PUSH: begin
        if (stack_full) begin
          status = ST_FULL;
        end else begin
          result           = tag_in_w;
          stack_ctl.push   = 1'b1;
          stack_level_next = stack_level + 1'b1;
        end
      end
      CMD_CLOSE: begin
        if (stack_empty) begin
          status = ST_STACK_EMPTY;
        end else if (hist_full) begin
          status = ST_FULL;
        end else begin
          result             = stack_front;
          stack_ctl.pop      = 1'b1;
          hist_ctl.append    = 1'b1;
          stack_level_next   = stack_level - 1'b1;
          history_level_next = history_level + 1'b1;
        end
      end
      CMD_PEEK: begin
        if (stack_empty) begin
          status = ST_STACK_EMPTY;
        end else begin
          result = stack_front;
        end
      end
      default: begin
        if (hist_empty) begin
          status = ST_HISTORY_EMPTY;
        end else if (stack_full) begin
          status = ST_FULL;
        end else begin
          result             = hist_front;
          stack_new          = hist_front;
          hist_ctl.pop       = 1'b1;
          stack_ctl.push     = 1'b1;
          stack_level_next   = stack_level + 1'b1;
          history_level_next = history_level - 1'b1;
        end
      end
    endcase
    if (!accept) begin
      stack_ctl          = '0;
      hist_ctl           = '0;
      stack_level_next   = stack_level;
      history_level_next = history_level;
    end
  end

  lshf_chain #(
    .DEPTH     (STACK_DEPTH),
    .TAG_WIDTH (TAG_WIDTH),
    .IDX_W     (SLW)
  ) u_stack (
    .clk     (clk),
    .ctl     (stack_ctl),
    .idx     (stack_level),
    .new_tag (stack_new),
    .front   (stack_front)
  );

  lshf_chain #(
    .DEPTH     (HISTORY_DEPTH),
    .TAG_WIDTH (TAG_WIDTH),
    .IDX_W     (HLW)
  ) u_hist (
    .clk     (clk),
    .ctl     (hist_ctl),
    .idx     (history_level),
    .new_tag (stack_front),
    .front   (hist_front)
  );

  assign result_ext = {{TAG_PORT_W{1'b0}}, result};
  assign sc_ext     = {{COUNT_W{1'b0}}, stack_level_next};
  assign hc_ext     = {{COUNT_W{1'b0}}, history_level_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_level   <= '0;
      history_level <= '0;
      res.valid     <= 1'b0;
    end else begin
      stack_level   <= stack_level_next;
      history_level <= history_level_next;
      if (accept) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.tag_out       <= result_ext[TAG_PORT_W-1:0];
      res.status        <= status;
      res.stack_count   <= sc_ext[COUNT_W-1:0];
      res.history_count <= hc_ext[COUNT_W-1:0];
    end
  end

endmodule

// ----- src/lshf_checker.sv -----
// Port-level checks on the top level, bound to every instance of it.
// Depends on lshf_pkg and lifo_stack_with_history_fifo_unit.
`timescale 1ns / 1ps

module lshf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [lshf_pkg::TAG_PORT_W-1:0] tag_out,
  input logic [1:0]                      status,
  input logic [lshf_pkg::COUNT_W-1:0]    stack_count,
  input logic [lshf_pkg::COUNT_W-1:0]    history_count
);
  import lshf_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_accept_gives_beat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted command produced no result beat");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(tag_out) && $stable(status)
      && $stable(stack_count) && $stable(history_count)))
    else $error("stalled result changed");

  a_fail_zero_tag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> tag_out == '0)
    else $error("nonzero tag on failed command");

  a_empty_counts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_STACK_EMPTY)) |-> stack_count == '0)
    else $error("stack empty reported with entries on stack");

endmodule

bind lifo_stack_with_history_fifo_unit lshf_checker u_lshf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (cmd.valid),
  .in_ready      (cmd.ready),
  .out_valid     (res.valid),
  .out_ready     (res.ready),
  .tag_out       (res.tag_out),
  .status        (res.status),
  .stack_count   (res.stack_count),
  .history_count (res.history_count)
);
